### sv/dtmf_filter_bank_detector_defines.svh
// Assertion macros used by the DTMF detector top level.
`ifndef DTMF_FILTER_BANK_DETECTOR_DEFINES_SVH
`define DTMF_FILTER_BANK_DETECTOR_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define DTMF_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define DTMF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### sv/dtmf_pkg.sv
// Package with coefficients and shared types of the DTMF detector.
package dtmf_pkg;
    localparam int TONES = 7;
    localparam int ROWS = 4;
    localparam int COEF_FRAC = 22;
    localparam int COEF_WIDTH = 24;
    localparam int TONE_IDX_W = 3;

    localparam logic [7:0] RATIO_RESET = 8'd40;
    localparam logic [5:0] FRAME_RESET = 6'd32;
    localparam logic CFG_RATIO = 1'b0;
    localparam logic CFG_FRAME = 1'b1;

    function automatic logic signed [COEF_WIDTH-1:0] coef_a1(input logic [TONE_IDX_W-1:0] k);
        logic signed [COEF_WIDTH-1:0] r;
        unique case (k)
            3'd0: r = -24'sd7951426;
            3'd1: r = -24'sd7884170;
            3'd2: r = -24'sd7800900;
            3'd3: r = -24'sd7701371;
            3'd4: r = -24'sd7317108;
            3'd5: r = -24'sd7120522;
            default: r = -24'sd6881545;
        endcase
        return r;
    endfunction

    function automatic logic signed [COEF_WIDTH-1:0] coef_a2(input logic [TONE_IDX_W-1:0] k);
        return (k < 3'd4) ? 24'sd4064563 : 24'sd4032745;
    endfunction

    function automatic logic signed [COEF_WIDTH-1:0] coef_b0(input logic [TONE_IDX_W-1:0] k);
        return (k < 3'd4) ? 24'sd64870 : 24'sd80779;
    endfunction

    // Control fields for the datapath; the detector in this project does not use this type.
    typedef struct packed {
        logic                  mac_en;
        logic [1:0]            term;
        logic [TONE_IDX_W-1:0] tone;
        logic                  finish;
        logic                  frame_end;
    } mac_ctrl_t;
endpackage

### sv/dtmf_tone_ram.sv
// Synchronous tone state memory: y1, y2, peak and amplitude per tone.
module dtmf_tone_ram #(
    parameter int STATE_WIDTH = 32
) (
    input  logic                              aclk,
    input  logic                              we,
    input  logic [dtmf_pkg::TONE_IDX_W-1:0]   waddr,
    input  logic [4*STATE_WIDTH-1:0]          wdata,
    input  logic [dtmf_pkg::TONE_IDX_W-1:0]   raddr,
    output logic [4*STATE_WIDTH-1:0]          rdata
);
    logic [4*STATE_WIDTH-1:0] mem [dtmf_pkg::TONES];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### sv/dtmf_filter_bank_detector.sv
// Top level of the DTMF filter bank detector.
// Each accepted sample runs through a slot for each of the seven tones
// in turn: a read of its state from the tone memory, multiply-accumulate
// steps on the one shared multiplier (three products), and a write of the
// state back. After the last slot, a tone test checks the rows in order
// and then the columns against ratio_threshold (Q4.4) times the sum of
// the other amplitudes of the group. The result is then loaded into the
// output registers, and only after that is the next sample accepted, so a
// new sample is not taken before the last one is through. A result that
// waits in the output registers does not hold off the next sample; only a
// second finished result waits for the first to be taken. Right after
// reset, the tone memory is cleared, and no sample is accepted during
// that time.
module dtmf_filter_bank_detector #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int STATE_WIDTH  = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] s_sample,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [3:0]                     m_symbol,
    output logic [2:0]                     m_row_hit,
    output logic [1:0]                     m_column_hit,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [7:0]                     cfg_data
);
    localparam int SW = STATE_WIDTH;
    localparam int DW = SAMPLE_WIDTH + 1;
    localparam int QW = (DW > 17 ? DW : 17) + 1;
    localparam int AW = SW + 26;
    localparam int TW = dtmf_pkg::TONE_IDX_W;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_MAC, ST_WRITE, ST_TEST, ST_OUT
    } state_t;

    state_t state_reg;
    logic [7:0] ratio_reg;
    logic [5:0] frame_limit_reg, frame_cnt_reg;
    logic signed [SAMPLE_WIDTH-1:0] x1_reg, x2_reg;
    logic signed [QW-1:0] dq_reg;
    logic [TW-1:0] tone_reg;
    logic [1:0] term_reg;
    logic frame_end_reg;
    logic signed [AW-1:0] acc_reg;
    logic [SW-1:0] amp_reg [dtmf_pkg::TONES];
    logic [2:0] row_reg;
    logic [1:0] col_reg;
    logic [3:0] sym_reg;
    logic [2:0] row_out_reg;
    logic [1:0] col_out_reg;
    logic out_valid_reg;

    logic ram_we;
    logic [TW-1:0] ram_raddr;
    logic [4*SW-1:0] ram_wdata, ram_rdata;

    dtmf_tone_ram #(.STATE_WIDTH(SW)) u_ram (
        .aclk(aclk), .we(ram_we), .waddr(tone_reg), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );
    assign ram_raddr = tone_reg;

    logic signed [SW-1:0] y1_rd, y2_rd;
    logic [SW-1:0] peak_rd, amp_rd;
    assign y1_rd = ram_rdata[SW-1:0];
    assign y2_rd = ram_rdata[2*SW-1:SW];
    assign peak_rd = ram_rdata[3*SW-1:2*SW];
    assign amp_rd = ram_rdata[4*SW-1:3*SW];

    // Shared multiplier: one product per cycle.
    logic signed [SW-1:0] mul_a;
    logic signed [dtmf_pkg::COEF_WIDTH-1:0] mul_c;
    logic signed [AW-1:0] prod;
    always_comb begin
        unique case (term_reg)
            2'd0: begin
                mul_a = SW'(dq_reg);
                mul_c = dtmf_pkg::coef_b0(tone_reg);
            end
            2'd1: begin
                mul_a = y1_rd;
                mul_c = -dtmf_pkg::coef_a1(tone_reg);
            end
            default: begin
                mul_a = y2_rd;
                mul_c = -dtmf_pkg::coef_a2(tone_reg);
            end
        endcase
        prod = AW'(mul_a) * AW'(mul_c);
    end

    // Rounding and saturation of the filter output, and the tone state written back.
    logic signed [AW-1:0] rnd;
    logic signed [AW-dtmf_pkg::COEF_FRAC-1:0] ysh;
    logic signed [SW-1:0] y_sat;
    logic [SW-1:0] mag, peak_new, amp_new;
    localparam logic signed [SW-1:0] YMAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] YMIN = {1'b1, {(SW-1){1'b0}}};
    always_comb begin
        rnd = acc_reg + (AW'(1) <<< (dtmf_pkg::COEF_FRAC - 1));
        ysh = rnd[AW-1:dtmf_pkg::COEF_FRAC];
        if (ysh > (AW-dtmf_pkg::COEF_FRAC)'(YMAX)) begin
            y_sat = YMAX;
        end else if (ysh < (AW-dtmf_pkg::COEF_FRAC)'(YMIN)) begin
            y_sat = YMIN;
        end else begin
            y_sat = ysh[SW-1:0];
        end
        mag = y_sat[SW-1] ? SW'(-y_sat) : y_sat;
        peak_new = (mag > peak_rd) ? mag : peak_rd;
        amp_new = SW'(({1'b0, peak_new} + {1'b0, amp_rd}) >> 1);
        if (state_reg == ST_CLEAR) begin
            ram_wdata = '0;
        end else if (frame_end_reg) begin
            ram_wdata = {amp_new, {SW{1'b0}}, y1_rd, y_sat};
        end else begin
            ram_wdata = {amp_rd, peak_new, y1_rd, y_sat};
        end
        ram_we = (state_reg == ST_CLEAR) || (state_reg == ST_WRITE);
    end

    // Tone test of one tone against the others of its group.
    logic is_row;
    logic [SW+2:0] others;
    logic [SW+11:0] lhs, rhs;
    logic wins;
    always_comb begin
        is_row = tone_reg < TW'(dtmf_pkg::ROWS);
        others = '0;
        for (int i = 0; i < dtmf_pkg::TONES; i++) begin
            if ((TW'(i) != tone_reg) && ((i < dtmf_pkg::ROWS) == is_row)) begin
                others = others + (SW+3)'(amp_reg[i]);
            end
        end
        lhs = (SW+12)'(amp_reg[tone_reg]) << 4;
        rhs = (SW+12)'(others) * (SW+12)'(ratio_reg);
        wins = lhs > rhs;
    end

    // The sample difference is brought to 16 fraction bits.
    logic signed [QW-1:0] dq_next;
    always_comb begin
        if (SAMPLE_WIDTH <= 17) begin
            dq_next = (QW'(s_sample) - QW'(x2_reg)) <<< (17 - SAMPLE_WIDTH);
        end else begin
            dq_next = (QW'(s_sample) - QW'(x2_reg)) >>> (SAMPLE_WIDTH - 17);
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;
    assign m_symbol = sym_reg;
    assign m_row_hit = row_out_reg;
    assign m_column_hit = col_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            ratio_reg <= dtmf_pkg::RATIO_RESET;
            frame_limit_reg <= dtmf_pkg::FRAME_RESET;
            frame_cnt_reg <= '0;
            x1_reg <= '0;
            x2_reg <= '0;
            tone_reg <= '0;
            term_reg <= '0;
            frame_end_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < dtmf_pkg::TONES; i++) begin
                amp_reg[i] <= '0;
            end
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    dtmf_pkg::CFG_RATIO: ratio_reg <= cfg_data;
                    default: frame_limit_reg <= cfg_data[5:0];
                endcase
            end
            // In ST_OUT the output registers are reloaded below instead.
            if (out_valid_reg && m_ready && state_reg != ST_OUT) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    if (tone_reg == TW'(dtmf_pkg::TONES - 1)) begin
                        tone_reg <= '0;
                        state_reg <= ST_IDLE;
                    end else begin
                        tone_reg <= tone_reg + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        dq_reg <= dq_next;
                        x2_reg <= x1_reg;
                        x1_reg <= s_sample;
                        frame_end_reg <= frame_cnt_reg >= frame_limit_reg;
                        frame_cnt_reg <= (frame_cnt_reg >= frame_limit_reg) ? '0
                                         : frame_cnt_reg + 1'b1;
                        tone_reg <= '0;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    term_reg <= '0;
                    acc_reg <= '0;
                    state_reg <= ST_MAC;
                end
                ST_MAC: begin
                    acc_reg <= acc_reg + prod;
                    term_reg <= term_reg + 1'b1;
                    if (term_reg == 2'd2) begin
                        state_reg <= ST_WRITE;
                    end
                end
                ST_WRITE: begin
                    amp_reg[tone_reg] <= frame_end_reg ? amp_new : amp_rd;
                    if (tone_reg == TW'(dtmf_pkg::TONES - 1)) begin
                        tone_reg <= '0;
                        row_reg <= '0;
                        col_reg <= '0;
                        state_reg <= ST_TEST;
                    end else begin
                        tone_reg <= tone_reg + 1'b1;
                        state_reg <= ST_READ;
                    end
                end
                ST_TEST: begin
                    if (wins) begin
                        if (is_row && row_reg == '0) begin
                            row_reg <= 3'(tone_reg) + 3'd1;
                        end else if (!is_row && col_reg == '0) begin
                            col_reg <= 2'(tone_reg - 3'd3);
                        end
                    end
                    if (tone_reg == TW'(dtmf_pkg::TONES - 1)) begin
                        state_reg <= ST_OUT;
                    end else begin
                        tone_reg <= tone_reg + 1'b1;
                    end
                end
                default: begin
                    if (!out_valid_reg || m_ready) begin
                        sym_reg <= (row_reg != '0 && col_reg != '0)
                                   ? 4'(col_reg) + 4'd3 * 4'(row_reg - 3'd1) : 4'd0;
                        row_out_reg <= row_reg;
                        col_out_reg <= col_reg;
                        out_valid_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    `include "dtmf_filter_bank_detector_defines.svh"

    `DTMF_ASSERT_IMP(a_sym_needs_both, aclk, aresetn, m_valid && m_symbol != 4'd0, m_row_hit != 3'd0 && m_column_hit != 2'd0)
    `DTMF_ASSERT_NEXT(a_accept_starts, aclk, aresetn, s_valid && s_ready, state_reg == ST_READ)
    `DTMF_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_symbol) && $stable(m_row_hit) && $stable(m_column_hit))
endmodule

### tb/sv/dtmf_scoreboard.sv
// Checker for the DTMF detector: predicts each result word and compares it with the block.
module dtmf_scoreboard (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic signed [15:0] s_sample,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [3:0]        m_symbol,
    input  logic [2:0]        m_row_hit,
    input  logic [1:0]        m_column_hit,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [7:0]        cfg_data,
    output int                fail_count,
    output int                pending,
    output int                tone_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TONES = dtmf_pkg::TONES;
    localparam int ROWS  = dtmf_pkg::ROWS;

    typedef struct packed {
        logic [3:0] symbol;
        logic [2:0] row_hit;
        logic [1:0] column_hit;
    } detection_t;

    // Band-pass coefficients in Q2.22, rows first, then columns.
    localparam longint A1 [TONES] = '{-7951426, -7884170, -7800900, -7701371,
                                      -7317108, -7120522, -6881545};
    localparam longint A2_ROW = 4064563;
    localparam longint A2_COL = 4032745;
    localparam longint B0_ROW = 64870;
    localparam longint B0_COL = 80779;
    localparam longint Y_MAX  = 64'sd2147483647;
    localparam longint Y_MIN  = -64'sd2147483648;

    logic [7:0]      ratio_q44;
    logic [5:0]      frame_len;
    longint          x_hist [2];
    longint          y_hist [2*TONES];
    longint unsigned peak_mag [TONES];
    longint unsigned tone_amp [TONES];
    logic [5:0]      frame_count;
    detection_t      detections_due [$];

    function automatic bit dominates(int self, int first, int count);
        longint unsigned others;
        others = 0;
        for (int i = first; i < first + count; i++)
            if (i != self) others += tone_amp[i];
        return tone_amp[self] * 16 > longint'(ratio_q44) * others;
    endfunction

    function automatic detection_t detect_tones(logic signed [15:0] smp);
        detection_t      d;
        longint          dq, acc, y, a2, b0;
        longint unsigned mag;
        d = '0;
        dq = (longint'(smp) - x_hist[1]) * 2;
        for (int k = 0; k < TONES; k++) begin
            a2 = (k < ROWS) ? A2_ROW : A2_COL;
            b0 = (k < ROWS) ? B0_ROW : B0_COL;
            acc = b0 * dq - A1[k] * y_hist[2*k] - a2 * y_hist[2*k+1];
            y = (acc + (64'sd1 <<< (dtmf_pkg::COEF_FRAC - 1))) >>> dtmf_pkg::COEF_FRAC;
            if (y > Y_MAX) y = Y_MAX;
            if (y < Y_MIN) y = Y_MIN;
            mag = (y < 0) ? longint'(-y) : longint'(y);
            y_hist[2*k+1] = y_hist[2*k];
            y_hist[2*k] = y;
            if (mag > peak_mag[k]) peak_mag[k] = mag;
        end
        x_hist[1] = x_hist[0];
        x_hist[0] = longint'(smp);
        if (frame_count >= frame_len) begin
            frame_count = '0;
            for (int k = 0; k < TONES; k++) begin
                tone_amp[k] = (peak_mag[k] + tone_amp[k]) >> 1;
                peak_mag[k] = 0;
            end
        end else begin
            frame_count = frame_count + 6'd1;
        end
        for (int k = 0; k < ROWS; k++)
            if (dominates(k, 0, ROWS)) begin
                d.row_hit = 3'(k + 1);
                break;
            end
        for (int k = ROWS; k < TONES; k++)
            if (dominates(k, ROWS, TONES - ROWS)) begin
                d.column_hit = 2'(k - ROWS + 1);
                break;
            end
        if (d.row_hit != 0 && d.column_hit != 0)
            d.symbol = 4'(d.column_hit + 3 * (d.row_hit - 1));
        return d;
    endfunction

    assign pending = detections_due.size();

    always @(posedge aclk) begin
        detection_t want;
        bit         bad;
        if (!aresetn) begin
            ratio_q44 <= dtmf_pkg::RATIO_RESET;
            frame_len <= dtmf_pkg::FRAME_RESET;
            frame_count = '0;
            x_hist = '{0, 0};
            for (int i = 0; i < 2*TONES; i++) y_hist[i] = 0;
            for (int i = 0; i < TONES; i++) begin
                peak_mag[i] = 0;
                tone_amp[i] = 0;
            end
            detections_due.delete();
            fail_count <= 0;
            tone_hits <= 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == dtmf_pkg::CFG_RATIO) ratio_q44 <= cfg_data;
                else frame_len <= cfg_data[5:0];
            end
            if (s_valid && s_ready)
                detections_due.push_back(detect_tones(s_sample));
            if (m_valid && m_ready) begin
                if (detections_due.size() == 0) begin
                    $error("result word arrived with nothing expected");
                    fail_count <= fail_count + 1;
                end else begin
                    want = detections_due.pop_front();
                    bad = 1'b0;
                    if (want.symbol != 0) tone_hits <= tone_hits + 1;
                    if (m_symbol !== want.symbol) begin
                        $error("symbol: expected %0d, got %0d", want.symbol, m_symbol);
                        bad = 1'b1;
                    end
                    if (m_row_hit !== want.row_hit) begin
                        $error("row_hit: expected %0d, got %0d", want.row_hit, m_row_hit);
                        bad = 1'b1;
                    end
                    if (m_column_hit !== want.column_hit) begin
                        $error("column_hit: expected %0d, got %0d",
                               want.column_hit, m_column_hit);
                        bad = 1'b1;
                    end
                    if (bad) fail_count <= fail_count + 1;
                end
            end
        end
    end
endmodule

### tb/sv/tb_dtmf_filter_bank_detector.sv
// Testbench top for the DTMF detector: clock, reset, stimulus and verdict.
module tb_dtmf_filter_bank_detector;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int    CYCLE_LIMIT = 600000;
    localparam int    PHASES      = 6;
    localparam int    PHASE_WORDS = 190;
    localparam int    CALM_WORDS  = 150;
    localparam int    DRAIN_WAIT  = 60;
    localparam real   FS = 16000.0;
    localparam real   TWO_PI = 6.283185307179586;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic signed [15:0] s_sample = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [3:0]        m_symbol;
    logic [2:0]        m_row_hit;
    logic [1:0]        m_column_hit;
    logic              cfg_we = 1'b0;
    logic              cfg_index = dtmf_pkg::CFG_RATIO;
    logic [7:0]        cfg_data = '0;

    int  fail_count, pending, tone_hits;
    int  words_sent = 0;
    int  cycle_count = 0;
    bit  calm = 1'b0;        // last stretch of the run: no idling on either side
    bit  hold_request = 1'b0;
    bit  hold_done = 1'b0;

    real row_freq [4] = '{697.0, 770.0, 852.0, 941.0};
    real col_freq [3] = '{1209.0, 1336.0, 1477.0};

    always #4 aclk = ~aclk;

    dtmf_filter_bank_detector u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_sample(s_sample),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_symbol(m_symbol), .m_row_hit(m_row_hit), .m_column_hit(m_column_hit),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    dtmf_scoreboard u_scoreboard (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_sample(s_sample),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_symbol(m_symbol), .m_row_hit(m_row_hit), .m_column_hit(m_column_hit),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending), .tone_hits(tone_hits)
    );

    // A hung handshake must not hang the run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // The result side stalls in random bursts. Once, on request from the
    // stimulus, it holds off long enough for the block to back up and drop
    // s_ready while the sample side keeps offering words.
    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_request && !hold_done) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_done = 1'b1;
            end else if (!calm && $urandom_range(0, 6) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Offers one word and waits for the handshake. Unless the task idles at random,
    // valid stays high on return, so a back-to-back word keeps it high without a glitch.
    task automatic send_word(logic signed [15:0] value);
        s_valid <= 1'b1;
        s_sample <= value;
        @(posedge aclk iff s_ready);
        words_sent++;
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
    endtask

    // Waits until every result word has come back, plus the block's latency,
    // so that a register write lands on an idle block.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // One register write; the enable drops again before the next one.
    task automatic write_reg(logic index, logic [7:0] value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic signed [15:0] clip(real v);
        if (v > 32767.0) return 16'sd32767;
        if (v < -32768.0) return -16'sd32768;
        return 16'($rtoi(v));
    endfunction

    // A burst of dual-tone signal. A row or column of zero leaves that group
    // silent, which covers the row-only and column-only cases.
    task automatic tone_burst(int row, int col, int len, real amp_r, real amp_c, int noise);
        real v;
        for (int n = 0; n < len; n++) begin
            v = $itor($urandom_range(0, 2 * noise)) - $itor(noise);
            if (row != 0) v += amp_r * $sin(TWO_PI * row_freq[row-1] * n / FS);
            if (col != 0) v += amp_c * $sin(TWO_PI * col_freq[col-1] * n / FS);
            send_word(clip(v));
        end
    endtask

    // Full-scale square wave at one resonance, to push the filters into saturation.
    task automatic square_burst(int len);
        real f;
        f = ($urandom_range(0, 1) == 0) ? row_freq[$urandom_range(0, 3)]
                                       : col_freq[$urandom_range(0, 2)];
        for (int n = 0; n < len; n++)
            send_word($sin(TWO_PI * f * n / FS) >= 0.0 ? 16'sd32767 : -16'sd32768);
    endtask

    initial begin
        logic [7:0] ratio_set [PHASES];
        logic [5:0] frame_set [PHASES];
        int         goal, pick, len, left;
        bit         short_frame_done;
        ratio_set = '{8'd40, 8'd0, 8'd255, 8'd24, 8'($urandom_range(0, 255)), 8'd40};
        frame_set = '{6'd32, 6'd0, 6'd63, 6'd1, 6'($urandom_range(0, 63)), 6'd16};
        short_frame_done = 1'b0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed words at reset settings: field extremes, small values and alternating-bit patterns.
        send_word(16'sd32767);
        send_word(-16'sd32768);
        send_word(16'sd0);
        send_word(-16'sd1);
        send_word(16'sd1);
        send_word(16'sh5555);
        send_word(16'shAAAA);
        send_word(-16'sd32768);
        send_word(16'sd32767);
        send_word(16'sd32767);
        send_word(-16'sd32768);
        square_burst(14);

        for (int p = 0; p < PHASES; p++) begin
            // Between phases the sample side waits for every result first.
            drain();
            write_reg(dtmf_pkg::CFG_RATIO, ratio_set[p]);
            write_reg(dtmf_pkg::CFG_FRAME, {2'b00, frame_set[p]});
            if (p == PHASES - 1) calm = 1'b1;
            goal = words_sent + ((p == PHASES - 1) ? CALM_WORDS : PHASE_WORDS);
            while (words_sent < goal) begin
                if (p == 0 && words_sent > 60) hold_request = 1'b1;
                // Frame length 2: the next word ends the frame unless the count is below 2.
                if (p == 2 && !short_frame_done && words_sent >= goal - 100) begin
                    short_frame_done = 1'b1;
                    drain();
                    write_reg(dtmf_pkg::CFG_FRAME, 8'd2);
                end
                left = goal - words_sent;
                pick = $urandom_range(0, 19);
                len = (pick < 14) ? $urandom_range(24, 120) : $urandom_range(8, 40);
                if (len > left) len = left;
                if (pick < 14)
                    tone_burst($urandom_range(0, 4), $urandom_range(0, 3), len,
                               $itor($urandom_range(1000, 15000)),
                               $itor($urandom_range(1000, 15000)),
                               $urandom_range(0, 800));
                else if (pick < 17)
                    tone_burst(0, 0, len, 0.0, 0.0, 32767);
                else
                    square_burst(len);
            end
        end

        drain();
        $display("Sent %0d samples over %0d register settings; %0d results named a key.",
                 words_sent, PHASES, tone_hits);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
